// ----- sv/record_stack_search_reverse_defines.svh -----
// Assertion macros for the record stack with key search and reversal.
// Included by the controller and the datapath; no other dependencies.
`ifndef RECORD_STACK_SEARCH_REVERSE_DEFINES_SVH
`define RECORD_STACK_SEARCH_REVERSE_DEFINES_SVH
`ifndef SYNTH
`define RSSR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RSSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSSR_ASSERT(lbl, clk, rstn, prop, msg)
`define RSSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- sv/rssr_pkg.sv -----
// Shared types, constants and helpers of the record stack.
// No dependencies; used by the controller, the datapath and the top level.
package rssr_pkg;

    localparam int HALF_W      = 56;
    localparam int PAIR_W      = 2 * HALF_W;
    localparam int MAX_BYTES   = 14;
    localparam int ENTRY_W     = 5;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 240;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_SEARCH  = 2'd2,
        ACT_REVERSE = 2'd3
    } t_action;

    typedef struct packed {
        logic [HALF_W-1:0] nl;
        logic [HALF_W-1:0] nh;
        logic [HALF_W-1:0] kl;
        logic [HALF_W-1:0] kh;
    } t_rec;

    // first field in the highest bits
    typedef struct packed {
        logic [HALF_W-1:0] name_low;
        logic [HALF_W-1:0] name_high;
        logic [HALF_W-1:0] key_low;
        logic [HALF_W-1:0] key_high;
        t_action           action;
    } t_in_beat;

    typedef struct packed {
        logic               is_empty;
        logic [ENTRY_W-1:0] entry_count;
        logic               overflow;
        logic               underflow;
        logic               found;
        logic [HALF_W-1:0]  out_name_low;
        logic [HALF_W-1:0]  out_name_high;
        logic [HALF_W-1:0]  out_key_low;
        logic [HALF_W-1:0]  out_key_high;
    } t_out_beat;

    localparam int IN_W  = $bits(t_in_beat);
    localparam int OUT_W = $bits(t_out_beat);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_PUSH    = 9'b000000010,
        ST_POP     = 9'b000000100,
        ST_SRCH    = 9'b000001000,
        ST_REV_RDA = 9'b000010000,
        ST_REV_RDB = 9'b000100000,
        ST_REV_WRA = 9'b001000000,
        ST_REV_WRB = 9'b010000000,
        ST_FIN     = 9'b100000000
    } t_state;

    typedef struct packed {
        logic cap;
        logic push;
        logic pop;
        logic srch_rd;
        logic rev_rd_a;
        logic rev_rd_b;
        logic rev_wr_a;
        logic rev_wr_b;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic srch_more;
        logic rev_more;
    } t_dp_sts;

    // keep the first nbytes bytes of a 112-bit pair, byte 0 on top
    function automatic logic [PAIR_W-1:0] byte_mask(input int unsigned nbytes);
        logic [PAIR_W-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_BYTES; p++) begin
            if (p < nbytes) begin
                m[PAIR_W-1-8*p -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- sv/rssr_ctrl.sv -----
// Controller of the record stack: sequences push, pop, search and reverse.
// Depends on rssr_pkg and record_stack_search_reverse_defines.svh.
`include "record_stack_search_reverse_defines.svh"
module rssr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rssr_pkg::t_action i_action,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output rssr_pkg::t_dp_cmd o_cmd,
    input  rssr_pkg::t_dp_sts i_sts
);

    rssr_pkg::t_state  r_state, n_state;
    logic              r_m_valid;
    rssr_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            rssr_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    cmd.cap = 1'b1;
                    unique case (i_action)
                        rssr_pkg::ACT_PUSH:    n_state = rssr_pkg::ST_PUSH;
                        rssr_pkg::ACT_POP:     n_state = rssr_pkg::ST_POP;
                        rssr_pkg::ACT_SEARCH:  n_state = rssr_pkg::ST_SRCH;
                        rssr_pkg::ACT_REVERSE: n_state = rssr_pkg::ST_REV_RDA;
                        default:               n_state = rssr_pkg::ST_IDLE;
                    endcase
                end
            end
            rssr_pkg::ST_PUSH: begin
                cmd.push = 1'b1;
                n_state  = rssr_pkg::ST_FIN;
            end
            rssr_pkg::ST_POP: begin
                cmd.pop = 1'b1;
                n_state = rssr_pkg::ST_FIN;
            end
            rssr_pkg::ST_SRCH: begin
                if (i_sts.srch_more) begin
                    cmd.srch_rd = 1'b1;
                end else begin
                    n_state = rssr_pkg::ST_FIN;
                end
            end
            rssr_pkg::ST_REV_RDA: begin
                if (i_sts.rev_more) begin
                    cmd.rev_rd_a = 1'b1;
                    n_state      = rssr_pkg::ST_REV_RDB;
                end else begin
                    n_state = rssr_pkg::ST_FIN;
                end
            end
            rssr_pkg::ST_REV_RDB: begin
                cmd.rev_rd_b = 1'b1;
                n_state      = rssr_pkg::ST_REV_WRA;
            end
            rssr_pkg::ST_REV_WRA: begin
                cmd.rev_wr_a = 1'b1;
                n_state      = rssr_pkg::ST_REV_WRB;
            end
            rssr_pkg::ST_REV_WRB: begin
                cmd.rev_wr_b = 1'b1;
                n_state      = rssr_pkg::ST_REV_RDA;
            end
            rssr_pkg::ST_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = rssr_pkg::ST_IDLE;
                end
            end
            default: n_state = rssr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rssr_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_ld) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_m_tvalid = r_m_valid;

    `RSSR_ASSERT(a_ld_when_free, i_clk, i_rst_n, !cmd.out_ld || !r_m_valid || i_m_tready, "result loaded over a pending beat")
    `RSSR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "second beat taken while busy")
    `RSSR_ASSERT_NEXT(a_fin_shows, i_clk, i_rst_n, cmd.out_ld, o_m_tvalid && (r_state == rssr_pkg::ST_IDLE), "finished result not shown")

endmodule

// ----- sv/rssr_dp.sv -----
// Datapath of the record stack: record memory, count, walk indices,
// key compare and the output register. Depends on rssr_pkg and the defines header.
`include "record_stack_search_reverse_defines.svh"
module rssr_dp #(
    parameter int DEPTH      = 16,
    parameter int KEY_BYTES  = 14,
    parameter int NAME_BYTES = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rssr_pkg::t_in_beat i_in,
    input  rssr_pkg::t_dp_cmd  i_cmd,
    output rssr_pkg::t_dp_sts  o_sts,
    output rssr_pkg::t_out_beat o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int HW = rssr_pkg::HALF_W;
    localparam int PW = rssr_pkg::PAIR_W;
    localparam logic [PW-1:0] KeyMask  = rssr_pkg::byte_mask(KEY_BYTES);
    localparam logic [PW-1:0] NameMask = rssr_pkg::byte_mask(NAME_BYTES);

    rssr_pkg::t_rec mem [DEPTH];
    rssr_pkg::t_rec r_rd_data, r_tmp;
    rssr_pkg::t_out_beat r_out;
    logic [HW-1:0]  r_kh, r_kl, r_nh, r_nl;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_lo;
    logic [AW-1:0]  r_hi;
    logic           r_found, r_uflow, r_oflow, r_pop, r_cmp_v;

    logic           full, empty;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_wa, mem_ra;
    rssr_pkg::t_rec mem_wd, push_rec;
    logic           key_fail;

    assign full  = (r_cnt == CW'(DEPTH));
    assign empty = (r_cnt == '0);

    assign push_rec.kh = r_kh & KeyMask[PW-1:HW];
    assign push_rec.kl = r_kl & KeyMask[HW-1:0];
    assign push_rec.nh = r_nh & NameMask[PW-1:HW];
    assign push_rec.nl = r_nl & NameMask[HW-1:0];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt[AW-1:0];
        mem_wd = push_rec;
        if (i_cmd.push && !full) begin
            mem_we = 1'b1;
        end else if (i_cmd.rev_wr_a) begin
            mem_we = 1'b1;
            mem_wa = r_lo[AW-1:0];
            mem_wd = r_rd_data;
        end else if (i_cmd.rev_wr_b) begin
            mem_we = 1'b1;
            mem_wa = r_hi;
            mem_wd = r_tmp;
        end
    end

    always_comb begin
        mem_re = 1'b0;
        mem_ra = AW'(r_cnt - 1'b1);
        if (i_cmd.pop && !empty) begin
            mem_re = 1'b1;
        end else if (i_cmd.srch_rd || i_cmd.rev_rd_a) begin
            mem_re = 1'b1;
            mem_ra = r_lo[AW-1:0];
        end else if (i_cmd.rev_rd_b) begin
            mem_re = 1'b1;
            mem_ra = r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
        if (i_cmd.rev_rd_b) begin
            r_tmp <= r_rd_data;
        end
    end

    // terminated-string compare: fail on a mismatch with no shared zero before it
    always_comb begin
        logic [PW-1:0] a, b;
        logic          term;
        a        = {r_kh, r_kl};
        b        = {r_rd_data.kh, r_rd_data.kl};
        term     = 1'b0;
        key_fail = 1'b0;
        for (int p = 0; p < KEY_BYTES && p < rssr_pkg::MAX_BYTES; p++) begin
            if ((a[PW-1-8*p -: 8] != b[PW-1-8*p -: 8]) && !term) begin
                key_fail = 1'b1;
            end
            if (a[PW-1-8*p -: 8] == 8'h00) begin
                term = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kh <= i_in.key_high;
            r_kl <= i_in.key_low;
            r_nh <= i_in.name_high;
            r_nl <= i_in.name_low;
        end
        if (i_cmd.cap) begin
            r_hi <= AW'(r_cnt - 1'b1);
        end else if (i_cmd.rev_wr_b) begin
            r_hi <= r_hi - 1'b1;
        end
        if (i_cmd.out_ld) begin
            r_out.out_key_high  <= r_pop ? r_rd_data.kh : '0;
            r_out.out_key_low   <= r_pop ? r_rd_data.kl : '0;
            r_out.out_name_high <= r_pop ? r_rd_data.nh : '0;
            r_out.out_name_low  <= r_pop ? r_rd_data.nl : '0;
            r_out.found         <= r_found;
            r_out.underflow     <= r_uflow;
            r_out.overflow      <= r_oflow;
            r_out.entry_count   <= rssr_pkg::ENTRY_W'(r_cnt);
            r_out.is_empty      <= empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lo    <= '0;
            r_found <= 1'b0;
            r_uflow <= 1'b0;
            r_oflow <= 1'b0;
            r_pop   <= 1'b0;
            r_cmp_v <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.srch_rd;
            if (i_cmd.cap) begin
                r_lo    <= '0;
                r_found <= 1'b0;
                r_uflow <= 1'b0;
                r_oflow <= 1'b0;
                r_pop   <= 1'b0;
            end else begin
                if (i_cmd.srch_rd || i_cmd.rev_wr_b) begin
                    r_lo <= r_lo + 1'b1;
                end
                if (r_cmp_v && !key_fail) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.push) begin
                    if (full) begin
                        r_oflow <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                if (i_cmd.pop) begin
                    if (empty) begin
                        r_uflow <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_pop <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_sts.srch_more = (r_lo < r_cnt);
    assign o_sts.rev_more  = !empty && (r_lo < CW'(r_hi));
    assign o_out           = r_out;

    `RSSR_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "record count beyond depth")
    `RSSR_ASSERT(a_cnt_step, i_clk, i_rst_n, !$past(i_rst_n) || r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + 1'b1 || r_cnt == $past(r_cnt) - 1'b1, "record count jumped")
    `RSSR_ASSERT_NEXT(a_oflow, i_clk, i_rst_n, i_cmd.push && full, r_oflow && r_cnt == CW'(DEPTH), "push on full stack not dropped")

endmodule

// ----- sv/record_stack_search_reverse.sv -----
// Channel   Dir  Beat contents
// s_axis    in   action, key_high, key_low, name_high, name_low
// m_axis    out  out_key_high/low, out_name_high/low, found, underflow, overflow,
//                entry_count, is_empty
// One item at a time; the result beat sits in an output register.
// Accept to result: push and pop run one work state, search reads each record in turn, reverse
// swaps pairs from both ends in states RDA, RDB, WRA, WRB; the single-port record memory sets the walk length.
// Reset (i_rst_n low, synchronous) empties the stack; memory contents are kept.
// A stalled result beat holds; the next item is taken meanwhile but waits to finish.
// Top level of the record stack; depends on rssr_pkg, rssr_ctrl and rssr_dp.
module record_stack_search_reverse #(
    parameter int DEPTH      = 16,
    parameter int KEY_BYTES  = 14,
    parameter int NAME_BYTES = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // action, key_high, key_low, name_high, name_low, zero fill
    input  logic [rssr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_key_high, out_key_low, out_name_high, out_name_low, found,
    // underflow, overflow, entry_count, is_empty, zero fill
    output logic [rssr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    rssr_pkg::t_in_beat  in_beat;
    rssr_pkg::t_out_beat out_beat;
    rssr_pkg::t_dp_cmd   cmd;
    rssr_pkg::t_dp_sts   sts;

    assign in_beat      = s_axis_tdata[rssr_pkg::IN_W-1:0];
    assign m_axis_tdata = {{(rssr_pkg::OUT_TDATA_W - rssr_pkg::OUT_W){1'b0}}, out_beat};

    rssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_action   (in_beat.action),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rssr_dp #(
        .DEPTH      (DEPTH),
        .KEY_BYTES  (KEY_BYTES),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_beat),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (out_beat)
    );

endmodule

// ----- verif/tb_record_stack_search_reverse.sv -----
// Self-checking testbench of the record stack: push, pop, key search and reversal.
// Drives directed and random beats with random stalls and checks each result beat
// against an internal stack predictor or a directed beat; depends on rssr_pkg and the top level only.
`timescale 1ns / 100ps

module tb_record_stack_search_reverse;

    localparam int DEPTH       = 16;
    localparam int KEY_BYTES   = 14;
    localparam int NAME_BYTES  = 14;
    localparam int RAND_ITEMS  = 355;
    localparam int CALM_FROM   = 300;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 100;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HALF_W      = rssr_pkg::HALF_W;
    localparam int PAIR_W      = rssr_pkg::PAIR_W;
    localparam int MAX_BYTES   = rssr_pkg::MAX_BYTES;
    localparam int ENTRY_W     = rssr_pkg::ENTRY_W;
    localparam int IN_W        = rssr_pkg::IN_W;
    localparam int OUT_W       = rssr_pkg::OUT_W;
    localparam int IN_TDATA_W  = rssr_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rssr_pkg::OUT_TDATA_W;

    typedef struct packed {
        rssr_pkg::t_in_beat  item;
        logic [7:0]          reps;
        logic                typed;
        rssr_pkg::t_out_beat want;
    } t_plan_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    rssr_pkg::t_rec      stack_mem [DEPTH];
    int                  fill_level;
    rssr_pkg::t_out_beat pending_results [$];
    t_plan_row           plan [$];
    logic [PAIR_W-1:0]   key_pool [8];
    int                  error_count;
    int                  beat_count;
    bit                  calm;
    bit                  hold_req;
    bit                  held;

    record_stack_search_reverse #(
        .DEPTH      (DEPTH),
        .KEY_BYTES  (KEY_BYTES),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [PAIR_W-1:0] rand_pair();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        return w[PAIR_W-1:0];
    endfunction

    // zero every byte from position nbytes on, byte 0 on top
    function automatic logic [PAIR_W-1:0] clear_tail_bytes(logic [PAIR_W-1:0] v, int nbytes);
        for (int p = nbytes; p < MAX_BYTES; p++) begin
            v[PAIR_W-1-8*p -: 8] = 8'h00;
        end
        return v;
    endfunction

    function automatic bit keys_match(logic [PAIR_W-1:0] a, logic [PAIR_W-1:0] b);
        logic [7:0] ba;
        logic [7:0] bb;
        for (int p = 0; p < KEY_BYTES; p++) begin
            ba = a[PAIR_W-1-8*p -: 8];
            bb = b[PAIR_W-1-8*p -: 8];
            if (ba != bb) begin
                return 1'b0;
            end
            if (ba == 8'h00) begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic rssr_pkg::t_out_beat apply_action(rssr_pkg::t_in_beat it);
        rssr_pkg::t_out_beat r;
        rssr_pkg::t_rec tmp;
        logic [PAIR_W-1:0] k;
        logic [PAIR_W-1:0] n;
        r = '0;
        case (it.action)
            rssr_pkg::ACT_PUSH: begin
                if (fill_level >= DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    k = clear_tail_bytes({it.key_high, it.key_low}, KEY_BYTES);
                    n = clear_tail_bytes({it.name_high, it.name_low}, NAME_BYTES);
                    stack_mem[fill_level].kh = k[PAIR_W-1:HALF_W];
                    stack_mem[fill_level].kl = k[HALF_W-1:0];
                    stack_mem[fill_level].nh = n[PAIR_W-1:HALF_W];
                    stack_mem[fill_level].nl = n[HALF_W-1:0];
                    fill_level++;
                end
            end
            rssr_pkg::ACT_POP: begin
                if (fill_level == 0) begin
                    r.underflow = 1'b1;
                end else begin
                    fill_level--;
                    r.out_key_high  = stack_mem[fill_level].kh;
                    r.out_key_low   = stack_mem[fill_level].kl;
                    r.out_name_high = stack_mem[fill_level].nh;
                    r.out_name_low  = stack_mem[fill_level].nl;
                end
            end
            rssr_pkg::ACT_SEARCH: begin
                for (int i = fill_level - 1; i >= 0; i--) begin
                    if (keys_match({it.key_high, it.key_low},
                                   {stack_mem[i].kh, stack_mem[i].kl})) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
                for (int i = 0; i < fill_level / 2; i++) begin
                    tmp = stack_mem[i];
                    stack_mem[i] = stack_mem[fill_level - 1 - i];
                    stack_mem[fill_level - 1 - i] = tmp;
                end
            end
        endcase
        r.entry_count = fill_level[ENTRY_W-1:0];
        r.is_empty    = (fill_level == 0);
        return r;
    endfunction

    function automatic rssr_pkg::t_out_beat status_only(bit fnd, bit unf, bit ovf, int cnt);
        rssr_pkg::t_out_beat r;
        r = '0;
        r.found       = fnd;
        r.underflow   = unf;
        r.overflow    = ovf;
        r.entry_count = cnt[ENTRY_W-1:0];
        r.is_empty    = (cnt == 0);
        return r;
    endfunction

    task automatic add_row(rssr_pkg::t_action act, logic [PAIR_W-1:0] key,
                           logic [PAIR_W-1:0] name, int reps, bit typed,
                           rssr_pkg::t_out_beat want);
        t_plan_row row;
        row.item.action    = act;
        row.item.key_high  = key[PAIR_W-1:HALF_W];
        row.item.key_low   = key[HALF_W-1:0];
        row.item.name_high = name[PAIR_W-1:HALF_W];
        row.item.name_low  = name[HALF_W-1:0];
        row.reps           = reps[7:0];
        row.typed          = typed;
        row.want           = want;
        plan.push_back(row);
    endtask

    // offer one beat from a falling edge, return at the falling edge after it is taken
    task automatic offer(rssr_pkg::t_in_beat it, bit typed, rssr_pkg::t_out_beat want);
        logic [IN_TDATA_W-1:0] word;
        rssr_pkg::t_out_beat pred;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        word = '0;
        word[IN_W-1:0] = it;
        s_axis_tdata  = word;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = apply_action(it);
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic report(string what, logic [HALF_W-1:0] got, logic [HALF_W-1:0] want);
        error_count++;
        $display("MISMATCH beat %0d %s: got %h expected %h", beat_count, what, got, want);
    endtask

    task automatic check_result(rssr_pkg::t_out_beat got);
        rssr_pkg::t_out_beat want;
        if (pending_results.size() == 0) begin
            report("unexpected beat", HALF_W'(got.entry_count), '0);
        end else begin
            want = pending_results.pop_front();
            if (got.out_key_high !== want.out_key_high)
                report("out_key_high", got.out_key_high, want.out_key_high);
            if (got.out_key_low !== want.out_key_low)
                report("out_key_low", got.out_key_low, want.out_key_low);
            if (got.out_name_high !== want.out_name_high)
                report("out_name_high", got.out_name_high, want.out_name_high);
            if (got.out_name_low !== want.out_name_low)
                report("out_name_low", got.out_name_low, want.out_name_low);
            if (got.found !== want.found)
                report("found", HALF_W'(got.found), HALF_W'(want.found));
            if (got.underflow !== want.underflow)
                report("underflow", HALF_W'(got.underflow), HALF_W'(want.underflow));
            if (got.overflow !== want.overflow)
                report("overflow", HALF_W'(got.overflow), HALF_W'(want.overflow));
            if (got.entry_count !== want.entry_count)
                report("entry_count", HALF_W'(got.entry_count), HALF_W'(want.entry_count));
            if (got.is_empty !== want.is_empty)
                report("is_empty", HALF_W'(got.is_empty), HALF_W'(want.is_empty));
        end
        beat_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata[OUT_W-1:0]);
        end
    end

    // result side: random stall bursts, one long hold-off, none near the end
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [PAIR_W-1:0] ones;
        logic [PAIR_W-1:0] key_ab_junk;
        logic [PAIR_W-1:0] key_ab_other;
        logic [PAIR_W-1:0] key_abc;
        logic [PAIR_W-1:0] alt_aa;
        logic [PAIR_W-1:0] alt_55;
        logic [PAIR_W-1:0] k;
        logic [PAIR_W-1:0] n;
        rssr_pkg::t_in_beat it;
        int pick;
        int term;
        bit filling;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        fill_level    = 0;
        error_count   = 0;
        beat_count    = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        held          = 1'b0;

        ones         = '1;
        alt_aa       = {14{8'hAA}};
        alt_55       = {14{8'h55}};
        key_ab_junk  = {8'h41, 8'h42, 8'h00, 32'hFFFF_FFFF, 56'h12_3456_789A_BCDE};
        key_ab_other = {8'h41, 8'h42, 8'h00, 32'h0000_0001, 56'h0};
        key_abc      = {8'h41, 8'h42, 8'h43, 32'h0, 56'h0};

        add_row(rssr_pkg::ACT_POP,     '0,           '0,     1,  1, status_only(0, 1, 0, 0));
        add_row(rssr_pkg::ACT_SEARCH,  ones,         '0,     1,  1, status_only(0, 0, 0, 0));
        add_row(rssr_pkg::ACT_REVERSE, '0,           '0,     1,  1, status_only(0, 0, 0, 0));
        add_row(rssr_pkg::ACT_PUSH,    ones,         ones,   1,  1, status_only(0, 0, 0, 1));
        add_row(rssr_pkg::ACT_SEARCH,  ones,         '0,     1,  1, status_only(1, 0, 0, 1));
        add_row(rssr_pkg::ACT_SEARCH,  ones - 1'b1,  '0,     1,  1, status_only(0, 0, 0, 1));
        add_row(rssr_pkg::ACT_PUSH,    '0,           alt_aa, 1,  1, status_only(0, 0, 0, 2));
        add_row(rssr_pkg::ACT_SEARCH,  '0,           '0,     1,  1, status_only(1, 0, 0, 2));
        add_row(rssr_pkg::ACT_PUSH,    key_ab_junk,  alt_55, 1,  0, '0);
        add_row(rssr_pkg::ACT_SEARCH,  key_ab_other, '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_SEARCH,  key_abc,      '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_REVERSE, '0,           '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_POP,     '0,           '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_PUSH,    alt_55,       alt_aa, 14, 0, '0);
        add_row(rssr_pkg::ACT_PUSH,    ones,         ones,   1,  1, status_only(0, 0, 1, 16));
        add_row(rssr_pkg::ACT_REVERSE, '0,           '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_SEARCH,  key_ab_other, '0,     1,  0, '0);
        add_row(rssr_pkg::ACT_POP,     ones,         ones,   16, 0, '0);
        add_row(rssr_pkg::ACT_POP,     '0,           '0,     1,  1, status_only(0, 1, 0, 0));

        for (int i = 0; i < 8; i++) begin
            k = rand_pair();
            if (i % 2 == 0) begin
                term = $urandom_range(0, MAX_BYTES - 1);
                k = (i % 4 == 0) ? clear_tail_bytes(k, term) : k;
                k[PAIR_W-1-8*term -: 8] = 8'h00;
            end
            key_pool[i] = k;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            repeat (plan[r].reps) offer(plan[r].item, plan[r].typed, plan[r].want);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == HOLD_AT) hold_req = 1'b1;
            if (i == CALM_FROM) calm = 1'b1;
            filling = ((i / 50) % 2 == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                it.action = rssr_pkg::ACT_REVERSE;
            else if (pick < 30)
                it.action = rssr_pkg::ACT_SEARCH;
            else if (pick < (filling ? 85 : 45))
                it.action = rssr_pkg::ACT_PUSH;
            else
                it.action = rssr_pkg::ACT_POP;
            k = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 7)] : rand_pair();
            if (it.action == rssr_pkg::ACT_SEARCH && $urandom_range(0, 2) == 0) begin
                // scramble the bytes after the terminator
                term = MAX_BYTES;
                for (int p = MAX_BYTES - 1; p >= 0; p--) begin
                    if (k[PAIR_W-1-8*p -: 8] == 8'h00) term = p;
                end
                for (int p = term + 1; p < MAX_BYTES; p++) begin
                    k[PAIR_W-1-8*p -: 8] = 8'($urandom_range(0, 255));
                end
            end
            n = rand_pair();
            it.key_high  = k[PAIR_W-1:HALF_W];
            it.key_low   = k[HALF_W-1:0];
            it.name_high = n[PAIR_W-1:HALF_W];
            it.name_low  = n[HALF_W-1:0];
            offer(it, 1'b0, '0);
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
